// ===== src/tfd_pkg.sv =====
// ----------------------------------------------------------------------------
// tfd_pkg
// shared types and constants of the length-prefixed frame deframer
// ----------------------------------------------------------------------------
package tfd_pkg;

    // header, record and frame layout
    localparam logic [7:0] HDR0           = 8'h55;
    localparam logic [7:0] HDR1           = 8'hAA;
    localparam logic [7:0] KIND_C5        = 8'hC5;
    localparam int         FRAME_OVERHEAD = 7;
    localparam int         RSSI_OFFSET    = 29;

    // crc-16/xmodem
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    // widths of the stream ports
    localparam int CFG_W   = 10;
    localparam int TDATA_W = 120;

    // frame status codes
    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_TRUNC    = 3'd1;
    localparam logic [2:0] STAT_CRC_ERR  = 3'd2;
    localparam logic [2:0] STAT_OTHER    = 3'd3;
    localparam logic [2:0] STAT_TOO_LONG = 3'd4;
    localparam logic [2:0] STAT_SHORT    = 3'd5;

    // end-of-frame request from the parser to the result emitter
    typedef struct packed {
        logic        valid;
        logic [2:0]  status;
        logic [7:0]  rssi_n;
        logic [31:0] distance;
        logic [31:0] angle;
        logic [31:0] pitch;
        logic [7:0]  rssi_total;
    } tfd_done_t;

endpackage

// ===== src/tfd_ram.sv =====
// ----------------------------------------------------------------------------
// tfd_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module tfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/tfd_parse.sv =====
// ----------------------------------------------------------------------------
// tfd_parse
// byte-serial frame parser: header hunt, length, crc, record capture
// ----------------------------------------------------------------------------
module tfd_parse #(
    parameter int MAX_PACKET = 1024,
    parameter int RSSI_MAX   = 32,
    parameter int IDX_W      = 5
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      byte_valid,
    input  logic [7:0]                rx_byte,
    input  logic [tfd_pkg::CFG_W-1:0] max_len,
    output logic                      ram_we,
    output logic [IDX_W-1:0]          ram_waddr,
    output logic [7:0]                ram_wdata,
    output tfd_pkg::tfd_done_t        done
);
    import tfd_pkg::*;

    localparam int CAP = MAX_PACKET - FRAME_OVERHEAD;

    typedef enum logic [7:0] {
        PH_HUNT0   = 8'b0000_0001,
        PH_HUNT1   = 8'b0000_0010,
        PH_SEQ     = 8'b0000_0100,
        PH_LEN_LO  = 8'b0000_1000,
        PH_LEN_HI  = 8'b0001_0000,
        PH_PAYLOAD = 8'b0010_0000,
        PH_CRC_HI  = 8'b0100_0000,
        PH_CRC_LO  = 8'b1000_0000
    } phase_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    phase_t      phase_reg, phase_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  trail_hi_reg, trail_hi_next;
    logic [7:0]  kind_reg, kind_next;
    logic [31:0] dist_reg, dist_next;
    logic [31:0] angle_reg, angle_next;
    logic [31:0] pitch_reg, pitch_next;
    logic [7:0]  cnt_reg, cnt_next;

    logic [15:0] limit;
    logic [15:0] len_full;
    logic [15:0] wr_off;
    logic [15:0] avail;
    logic [7:0]  n_calc;

    assign limit = ({6'b0, max_len} < 16'(CAP)) ? {6'b0, max_len} : 16'(CAP);
    assign len_full = {rx_byte, len_reg[7:0]};
    assign wr_off   = pos_reg - 16'(RSSI_OFFSET);
    assign avail    = len_reg - 16'(RSSI_OFFSET);

    // stored rssi count: min(count, bytes present, store depth)
    always_comb begin
        n_calc = cnt_reg;
        if (avail < {8'h00, n_calc}) begin
            n_calc = avail[7:0];
        end
        if (8'(RSSI_MAX) < n_calc) begin
            n_calc = 8'(RSSI_MAX);
        end
    end

    always_comb begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        len_next      = len_reg;
        crc_next      = crc_reg;
        trail_hi_next = trail_hi_reg;
        kind_next     = kind_reg;
        dist_next     = dist_reg;
        angle_next    = angle_reg;
        pitch_next    = pitch_reg;
        cnt_next      = cnt_reg;
        ram_we        = 1'b0;
        ram_waddr     = wr_off[IDX_W-1:0];
        ram_wdata     = rx_byte;
        done          = '0;
        if (byte_valid) begin
            case (phase_reg)
                PH_HUNT0: begin
                    if (rx_byte == HDR0) begin
                        phase_next = PH_HUNT1;
                    end
                end
                PH_HUNT1: begin
                    if (rx_byte == HDR1) begin
                        phase_next = PH_SEQ;
                    end else if (rx_byte != HDR0) begin
                        phase_next = PH_HUNT0;
                    end
                end
                PH_SEQ: begin
                    pos_next      = '0;
                    len_next      = '0;
                    crc_next      = CRC_INIT;
                    trail_hi_next = '0;
                    kind_next     = '0;
                    dist_next     = '0;
                    angle_next    = '0;
                    pitch_next    = '0;
                    cnt_next      = '0;
                    phase_next    = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    len_next   = {8'h00, rx_byte};
                    phase_next = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    len_next = len_full;
                    if (len_full > limit) begin
                        done.valid  = 1'b1;
                        done.status = STAT_TOO_LONG;
                        phase_next  = PH_HUNT0;
                    end else if (len_full == 16'd0) begin
                        phase_next = PH_CRC_HI;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (pos_reg == 16'd0) begin
                        kind_next = rx_byte;
                    end else if (pos_reg inside {[16:19]}) begin
                        dist_next[{pos_reg[1:0], 3'b000} +: 8] = rx_byte;
                    end else if (pos_reg inside {[20:23]}) begin
                        angle_next[{pos_reg[1:0], 3'b000} +: 8] = rx_byte;
                    end else if (pos_reg inside {[24:27]}) begin
                        pitch_next[{pos_reg[1:0], 3'b000} +: 8] = rx_byte;
                    end else if (pos_reg == 16'd28) begin
                        cnt_next = rx_byte;
                    end else if (pos_reg >= 16'(RSSI_OFFSET) && wr_off < 16'(RSSI_MAX)) begin
                        ram_we = 1'b1;
                    end
                    crc_next = crc16_byte(crc_reg, rx_byte);
                    pos_next = pos_reg + 16'd1;
                    if (pos_next >= len_reg) begin
                        phase_next = PH_CRC_HI;
                    end
                end
                PH_CRC_HI: begin
                    trail_hi_next = rx_byte;
                    phase_next    = PH_CRC_LO;
                end
                PH_CRC_LO: begin
                    done.valid = 1'b1;
                    phase_next = PH_HUNT0;
                    if ({trail_hi_reg, rx_byte} != crc_reg) begin
                        done.status = STAT_CRC_ERR;
                    end else if (kind_reg != KIND_C5) begin
                        done.status = STAT_OTHER;
                    end else if (len_reg < 16'(RSSI_OFFSET)) begin
                        done.status = STAT_SHORT;
                    end else begin
                        done.status     = (n_calc < cnt_reg) ? STAT_TRUNC : STAT_OK;
                        done.rssi_n     = n_calc;
                        done.distance   = dist_reg;
                        done.angle      = angle_reg;
                        done.pitch      = pitch_reg;
                        done.rssi_total = cnt_reg;
                    end
                end
                default: begin
                    phase_next = PH_HUNT0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT0;
        end else begin
            phase_reg <= phase_next;
        end
        pos_reg      <= pos_next;
        len_reg      <= len_next;
        crc_reg      <= crc_next;
        trail_hi_reg <= trail_hi_next;
        kind_reg     <= kind_next;
        dist_reg     <= dist_next;
        angle_reg    <= angle_next;
        pitch_reg    <= pitch_next;
        cnt_reg      <= cnt_next;
    end

endmodule

// ===== src/tfd_emit.sv =====
// ----------------------------------------------------------------------------
// tfd_emit
// result emitter: status result, then rssi results read back from the store
// ----------------------------------------------------------------------------
module tfd_emit #(
    parameter int IDX_W    = 5,
    parameter int CNT_W    = 6
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  tfd_pkg::tfd_done_t          done,
    output logic [IDX_W-1:0]            rd_addr,
    input  logic [7:0]                  rd_data,
    output logic                        byte_ok,
    output logic                        busy,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [tfd_pkg::TDATA_W-1:0] m_tdata,
    output logic                        m_tuser,
    output logic                        m_tlast
);
    import tfd_pkg::*;

    typedef enum logic [1:0] {
        EM_IDLE = 2'b01,
        EM_RSSI = 2'b10
    } emit_state_t;

    emit_state_t     state_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] n_reg;
    logic            rd_ok_reg;
    logic            valid_reg;
    logic [2:0]      status_reg;
    logic [31:0]     dist_reg;
    logic [31:0]     angle_reg;
    logic [31:0]     pitch_reg;
    logic [7:0]      total_reg;
    logic [7:0]      sample_reg;
    logic            is_rssi_reg;
    logic            last_reg;
    logic            out_free;
    logic            load_rssi;
    logic [CNT_W-1:0] idx_inc;

    assign out_free  = !valid_reg || m_tready;
    assign load_rssi = (state_reg == EM_RSSI) && out_free && rd_ok_reg;
    assign idx_inc   = idx_reg + CNT_W'(1);
    assign rd_addr   = idx_reg[IDX_W-1:0];
    assign byte_ok   = (state_reg == EM_IDLE) && out_free;
    assign busy      = (state_reg != EM_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= EM_IDLE;
            valid_reg <= 1'b0;
            rd_ok_reg <= 1'b0;
        end else begin
            rd_ok_reg <= 1'b1;
            case (state_reg)
                EM_IDLE: begin
                    if (done.valid) begin
                        valid_reg <= 1'b1;
                        rd_ok_reg <= 1'b0;
                        if (done.rssi_n != 8'd0) begin
                            state_reg <= EM_RSSI;
                        end
                    end else if (m_tready) begin
                        valid_reg <= 1'b0;
                    end
                end
                EM_RSSI: begin
                    if (load_rssi) begin
                        valid_reg <= 1'b1;
                        rd_ok_reg <= 1'b0;
                        if (idx_inc == n_reg) begin
                            state_reg <= EM_IDLE;
                        end
                    end else if (m_tready) begin
                        valid_reg <= 1'b0;
                    end
                end
                default: begin
                    state_reg <= EM_IDLE;
                    valid_reg <= 1'b0;
                end
            endcase
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if ((state_reg == EM_IDLE) && done.valid) begin
            status_reg  <= done.status;
            dist_reg    <= done.distance;
            angle_reg   <= done.angle;
            pitch_reg   <= done.pitch;
            total_reg   <= done.rssi_total;
            sample_reg  <= 8'h00;
            is_rssi_reg <= 1'b0;
            last_reg    <= (done.rssi_n == 8'd0);
            n_reg       <= CNT_W'(done.rssi_n);
            idx_reg     <= '0;
        end else if (load_rssi) begin
            sample_reg  <= rd_data;
            is_rssi_reg <= 1'b1;
            last_reg    <= (idx_inc == n_reg);
            idx_reg     <= idx_inc;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'b0, sample_reg, total_reg, pitch_reg, angle_reg, dist_reg, status_reg};
    assign m_tuser  = is_rssi_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== src/tlv_frame_deframer_crc16_top.sv =====
// ----------------------------------------------------------------------------
// tlv_frame_deframer_crc16_top
// deframer for 0x55 0xaa length-prefixed frames checked by crc-16/xmodem,
// with capture of the type-0xc5 record at the payload start and readout of its rssi bytes
// ----------------------------------------------------------------------------
//
// channel   dir  handshake            content
// --------  ---  -------------------  -------------------------------------------
// s_*       in   s_tvalid / s_tready  s_tdata[7:0] rx_byte
// m_*       out  m_tvalid / m_tready  m_tdata status/words/rssi, tuser, tlast
// cfg_*     in   cfg_valid/cfg_ready  cfg_data[9:0] max_payload_len
//
// one byte per cycle while a frame is parsed and the output register is free;
// the crc runs a byte per cycle; at frame end the status result is loaded,
// then each rssi result waits for the registered read of the rssi store
// s_tready stays low from the end-of-frame byte until the last result is
// loaded and the output register is free again
// aresetn is synchronous; max_payload_len returns to 1017, the rssi store
// is not cleared (only entries written in the current frame are read)
//
module tlv_frame_deframer_crc16_top #(
    parameter int MAX_PACKET = 1024,
    parameter int RSSI_MAX   = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // rx_byte
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] rx_byte
    // results
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [tfd_pkg::TDATA_W-1:0] m_tdata,   // [2:0] frame_status,
                                                   // [34:3] distance_bits,
                                                   // [66:35] angle_bits,
                                                   // [98:67] pitch_bits,
                                                   // [106:99] rssi_total,
                                                   // [114:107] rssi_sample
    output logic                        m_tuser,   // [0] is_rssi_item
    output logic                        m_tlast,   // last_of_frame
    // max_payload_len register
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tfd_pkg::CFG_W-1:0]   cfg_data
);
    import tfd_pkg::*;

    localparam int IDX_W = (RSSI_MAX > 1) ? $clog2(RSSI_MAX) : 1;
    localparam int CNT_W = $clog2(RSSI_MAX + 1);

    logic [CFG_W-1:0] max_len_reg;
    logic             byte_valid;
    logic             byte_ok;
    logic             emit_busy;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [7:0]       ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [7:0]       ram_rdata;
    tfd_done_t        done;

    // configuration is always taken; the user must write it only while the block is idle
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= CFG_W'(1017);
        end else if (cfg_valid) begin
            max_len_reg <= cfg_data;
        end
    end

    // a byte is taken only when the emitter could load a result for it
    assign s_tready   = byte_ok;
    assign byte_valid = s_tvalid && s_tready;

    tfd_parse #(
        .MAX_PACKET (MAX_PACKET),
        .RSSI_MAX   (RSSI_MAX),
        .IDX_W      (IDX_W)
    ) u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (byte_valid),
        .rx_byte    (s_tdata),
        .max_len    (max_len_reg),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .done       (done)
    );

    // rssi store: written by the parser, read back by the emitter
    tfd_ram #(
        .WIDTH   (8),
        .DEPTH   (RSSI_MAX),
        .AW      (IDX_W)
    ) u_rssi_ram (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    tfd_emit #(
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .done     (done),
        .rd_addr  (ram_raddr),
        .rd_data  (ram_rdata),
        .byte_ok  (byte_ok),
        .busy     (emit_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // end-of-frame requests come only from accepted bytes
    assert property (@(posedge aclk) disable iff (!aresetn)
        done.valid |-> (s_tvalid && s_tready))
        else $error("frame request without an accepted byte");

    // the store is never written while rssi results are being read out
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !emit_busy)
        else $error("rssi store written during readout");

    // rssi results only follow a good frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[2:0] == STAT_OK || m_tdata[2:0] == STAT_TRUNC))
        else $error("rssi result with a failing status");

    // after the final result of a frame is taken and no byte arrives, output is empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast && !(s_tvalid && s_tready)) |=> !m_tvalid)
        else $error("result shown after the end of a frame");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the crc-16 checked length-prefixed frame deframer;
// random byte streams with framing noise, bit-exact shadow parser, random
// back-pressure on the result stream, input gaps and several payload-limit settings
// ----------------------------------------------------------------------------
module tb_top;

    import tfd_pkg::*;

    localparam int PKT_MAX       = 1024;
    localparam int RSSI_DEPTH    = 32;
    localparam int RESET_CYCLES  = 5;
    // idle wait after the last expected result has been seen
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 400000;

    typedef enum logic [7:0] {
        P_HUNT0   = 8'b0000_0001,
        P_HUNT1   = 8'b0000_0010,
        P_SEQ     = 8'b0000_0100,
        P_LEN_LO  = 8'b0000_1000,
        P_LEN_HI  = 8'b0001_0000,
        P_PAYLOAD = 8'b0010_0000,
        P_CRC_HI  = 8'b0100_0000,
        P_CRC_LO  = 8'b1000_0000
    } parse_phase_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] distance;
        logic [31:0] angle;
        logic [31:0] pitch;
        logic [7:0]  rssi_total;
        logic [7:0]  rssi_sample;
        logic        is_rssi;
        logic        last;
    } frame_result_t;

    // shadow copy of the parser, fed with every accepted byte
    class deframer_shadow_t;
        logic [9:0]    max_len;
        parse_phase_t  phase;
        logic [15:0]   pos;
        logic [15:0]   plen;
        logic [15:0]   crc_run;
        logic [15:0]   crc_trailer;
        logic [7:0]    kind;
        logic [31:0]   distance;
        logic [31:0]   angle;
        logic [31:0]   pitch;
        logic [7:0]    rec_count;
        logic [7:0]    rssi_mem [RSSI_DEPTH];
        frame_result_t pending_results [$];
        int            n_errors;

        function new();
            max_len    = 10'd1017;
            phase      = P_HUNT0;
            pos        = '0;
            plen       = '0;
            crc_run    = CRC_INIT;
            crc_trailer = '0;
            kind       = '0;
            distance   = '0;
            angle      = '0;
            pitch      = '0;
            rec_count  = '0;
            n_errors   = 0;
        endfunction

        function int payload_limit();
            int cap;
            cap = PKT_MAX - FRAME_OVERHEAD;
            return (int'(max_len) < cap) ? int'(max_len) : cap;
        endfunction

        function logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
            logic [15:0] c;
            int i;
            c = crc ^ {b, 8'h00};
            for (i = 0; i < 8; i++)
                c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
            return c;
        endfunction

        function void push_result(logic [2:0] st, bit with_data, logic [7:0] sample,
                                  bit is_rssi, bit last);
            frame_result_t r;
            r.status      = st;
            r.distance    = with_data ? distance : '0;
            r.angle       = with_data ? angle : '0;
            r.pitch       = with_data ? pitch : '0;
            r.rssi_total  = with_data ? rec_count : '0;
            r.rssi_sample = sample;
            r.is_rssi     = is_rssi;
            r.last        = last;
            pending_results.push_back(r);
        endfunction

        function void capture(logic [7:0] b);
            int p;
            p = pos;
            if (p == 0)
                kind = b;
            else if (p >= 16 && p < 20)
                distance[8*(p-16) +: 8] = b;
            else if (p >= 20 && p < 24)
                angle[8*(p-20) +: 8] = b;
            else if (p >= 24 && p < 28)
                pitch[8*(p-24) +: 8] = b;
            else if (p == RSSI_OFFSET - 1)
                rec_count = b;
            else if (p >= RSSI_OFFSET && p - RSSI_OFFSET < RSSI_DEPTH)
                rssi_mem[p-RSSI_OFFSET] = b;
        endfunction

        function void close_frame();
            int avail;
            int n;
            int i;
            logic [2:0] st;
            if (crc_trailer != crc_run) begin
                push_result(STAT_CRC_ERR, 0, 8'h00, 0, 1);
            end else if (kind != KIND_C5) begin
                push_result(STAT_OTHER, 0, 8'h00, 0, 1);
            end else if (int'(plen) < RSSI_OFFSET) begin
                push_result(STAT_SHORT, 0, 8'h00, 0, 1);
            end else begin
                avail = int'(plen) - RSSI_OFFSET;
                n = int'(rec_count);
                if (avail < n) n = avail;
                if (RSSI_DEPTH < n) n = RSSI_DEPTH;
                st = (n < int'(rec_count)) ? STAT_TRUNC : STAT_OK;
                push_result(st, 1, 8'h00, 0, n == 0);
                for (i = 0; i < n; i++)
                    push_result(st, 1, rssi_mem[i], 1, i + 1 == n);
            end
        endfunction

        // one accepted request on the byte stream
        function void take_byte(logic [7:0] b);
            case (phase)
                P_HUNT0: begin
                    if (b == HDR0) phase = P_HUNT1;
                end
                P_HUNT1: begin
                    if (b == HDR1) phase = P_SEQ;
                    else if (b != HDR0) phase = P_HUNT0;
                end
                P_SEQ: begin
                    pos        = '0;
                    plen       = '0;
                    crc_run    = CRC_INIT;
                    crc_trailer = '0;
                    kind       = '0;
                    distance   = '0;
                    angle      = '0;
                    pitch      = '0;
                    rec_count  = '0;
                    phase      = P_LEN_LO;
                end
                P_LEN_LO: begin
                    plen  = {8'h00, b};
                    phase = P_LEN_HI;
                end
                P_LEN_HI: begin
                    plen[15:8] = b;
                    if (int'(plen) > payload_limit()) begin
                        push_result(STAT_TOO_LONG, 0, 8'h00, 0, 1);
                        phase = P_HUNT0;
                    end else begin
                        phase = (plen == 0) ? P_CRC_HI : P_PAYLOAD;
                    end
                end
                P_PAYLOAD: begin
                    capture(b);
                    crc_run = crc_byte(crc_run, b);
                    pos = pos + 16'd1;
                    if (pos >= plen) phase = P_CRC_HI;
                end
                P_CRC_HI: begin
                    crc_trailer = {b, 8'h00};
                    phase = P_CRC_LO;
                end
                default: begin
                    crc_trailer[7:0] = b;
                    phase = P_HUNT0;
                    close_frame();
                end
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                n_errors++;
            end
        endfunction

        function void check_result(frame_result_t got);
            frame_result_t want;
            if (pending_results.size() == 0) begin
                $error("result with no expectation: status %0d", got.status);
                n_errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("frame_status", 32'(want.status), 32'(got.status));
            compare_field("distance_bits", want.distance, got.distance);
            compare_field("angle_bits", want.angle, got.angle);
            compare_field("pitch_bits", want.pitch, got.pitch);
            compare_field("rssi_total", 32'(want.rssi_total), 32'(got.rssi_total));
            compare_field("rssi_sample", 32'(want.rssi_sample), 32'(got.rssi_sample));
            compare_field("is_rssi_item", 32'(want.is_rssi), 32'(got.is_rssi));
            compare_field("last_of_frame", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = 8'h00;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data  = '0;

    deframer_shadow_t sb;
    bit             tx_idle_on = 1'b1;
    bit             rx_idle_on = 1'b1;
    int             n_sent = 0;
    int unsigned    cycle_count = 0;

    always #2 aclk = ~aclk;

    tlv_frame_deframer_crc16_top #(
        .MAX_PACKET (PKT_MAX),
        .RSSI_MAX   (RSSI_DEPTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // run limit, far above the slowest legal run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: random stall bursts, every accepted result is checked
    initial begin : result_sink
        int stall_left;
        frame_result_t got;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.status      = m_tdata[2:0];
                got.distance    = m_tdata[34:3];
                got.angle       = m_tdata[66:35];
                got.pitch       = m_tdata[98:67];
                got.rssi_total  = m_tdata[106:99];
                got.rssi_sample = m_tdata[114:107];
                got.is_rssi     = m_tuser;
                got.last        = m_tlast;
                sb.check_result(got);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 9) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // one byte request; valid stays high afterwards unless a gap follows
    task automatic send_byte(input logic [7:0] b);
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        sb.take_byte(b);
        n_sent++;
    endtask

    task automatic send_noise(input int n);
        int i;
        for (i = 0; i < n; i++)
            send_byte(8'($urandom));
    endtask

    // full frame; oversize lengths stop after the length bytes, cut > 0 breaks it off
    task automatic send_frame(input int len, input logic [7:0] kind, input logic [7:0] rssi_n,
                              input bit bad_crc, input int cut);
        logic [7:0]  bytes_q [$];
        logic [7:0]  pb;
        logic [15:0] crc;
        int i;
        int n;
        bytes_q = {HDR0, HDR1, 8'($urandom), len[7:0], len[15:8]};
        if (len <= sb.payload_limit()) begin
            crc = CRC_INIT;
            for (i = 0; i < len; i++) begin
                pb = 8'($urandom);
                if (i == 0) pb = kind;
                else if (i == RSSI_OFFSET - 1) pb = rssi_n;
                crc = sb.crc_byte(crc, pb);
                bytes_q.push_back(pb);
            end
            if (bad_crc) crc = crc ^ 16'(1 << $urandom_range(0, 15));
            bytes_q.push_back(crc[15:8]);
            bytes_q.push_back(crc[7:0]);
        end
        n = (cut > 0 && cut < bytes_q.size()) ? cut : bytes_q.size();
        for (i = 0; i < n; i++)
            send_byte(bytes_q[i]);
    endtask

    function automatic int clamp_len(input int len);
        return (len > sb.payload_limit()) ? sb.payload_limit() : len;
    endfunction

    task automatic random_frame();
        int r;
        int len;
        int lim;
        int cnt;
        lim = sb.payload_limit();
        r = $urandom_range(0, 99);
        if (r < 60) begin
            // well-formed record, some with a damaged trailer
            len = clamp_len($urandom_range(RSSI_OFFSET, RSSI_OFFSET + 12));
            if ($urandom_range(0, 4) == 0)
                cnt = $urandom_range(0, 255);
            else
                cnt = $urandom_range(0, (len > RSSI_OFFSET) ? len - RSSI_OFFSET + 2 : 2);
            send_frame(len, KIND_C5, 8'(cnt), r >= 52, 0);
        end else if (r < 68) begin
            send_frame(clamp_len($urandom_range(1, RSSI_OFFSET - 1)), KIND_C5,
                       8'($urandom), 1'b0, 0);
        end else if (r < 76) begin
            send_frame(clamp_len($urandom_range(0, 20)), 8'($urandom), 8'($urandom),
                       1'b0, 0);
        end else if (r < 84) begin
            len = $urandom_range(0, 1) ? lim + 1 : $urandom_range(lim + 1, 65535);
            send_frame(len, KIND_C5, 8'($urandom), 1'b0, 0);
        end else if (r < 92) begin
            send_noise($urandom_range(1, 6));
        end else begin
            // frame broken off, the next header lands inside it
            len = clamp_len($urandom_range(1, 30));
            send_frame(len, KIND_C5, 8'($urandom), 1'b0, $urandom_range(1, len + 6));
        end
    endtask

    task automatic run_random(input int budget);
        int stop_at;
        stop_at = n_sent + budget;
        while (n_sent < stop_at)
            random_frame();
    endtask

    // finish any open frame with zero bytes, then wait for all results to drain
    task automatic drain_and_idle();
        while (sb.phase != P_HUNT0)
            send_byte(8'h00);
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [CFG_W-1:0] v);
        drain_and_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        sb.max_len = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic pick_idling();
        tx_idle_on = $urandom_range(0, 3) != 0;
        rx_idle_on = $urandom_range(0, 3) != 0;
    endtask

    initial begin : stimulus
        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed frames at the reset limit
        send_byte(HDR1);
        send_byte(HDR0);
        send_byte(HDR0);                          // repeated header start
        send_frame(31, KIND_C5, 8'd2, 1'b0, 0);    // plain record with two rssi bytes
        send_byte(HDR0);
        send_byte(8'h3C);                         // broken header restarts the hunt
        send_frame(29, KIND_C5, 8'd0, 1'b0, 0);    // no rssi, status is also last
        send_frame(64, KIND_C5, 8'd200, 1'b0, 0);  // count beyond the store depth
        send_frame(3, KIND_C5, 8'd3, 1'b1, 0);     // bad trailer
        send_frame(3, 8'h12, 8'd3, 1'b0, 0);       // other record type
        send_frame(0, 8'h00, 8'd0, 1'b0, 0);       // empty payload
        send_frame(1, KIND_C5, 8'd0, 1'b0, 0);     // type byte only
        send_frame(1018, KIND_C5, 8'd0, 1'b0, 0);  // just over the limit
        send_frame(65535, KIND_C5, 8'd0, 1'b0, 0); // largest length field

        // zero limit: only empty payloads pass
        write_limit(10'd0);
        pick_idling();
        send_frame(0, 8'h00, 8'd0, 1'b0, 0);
        send_frame(1, KIND_C5, 8'd0, 1'b0, 0);
        run_random(8);

        // register above the hard cap of 1017
        write_limit(10'd1023);
        pick_idling();
        send_frame(1018, KIND_C5, 8'd0, 1'b0, 0);
        run_random(8);

        // limit right at the record size
        write_limit(10'(RSSI_OFFSET));
        pick_idling();
        send_frame(RSSI_OFFSET, KIND_C5, 8'd1, 1'b0, 0);
        send_frame(RSSI_OFFSET + 1, KIND_C5, 8'd1, 1'b0, 0);
        run_random(8);

        write_limit(10'($urandom_range(30, 120)));
        pick_idling();
        run_random(15);

        // back to the reset value, no idling on either side at the end
        write_limit(10'd1017);
        pick_idling();
        run_random(15);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_random(25);

        drain_and_idle();
        if (sb.n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/tfd_pkg.sv
src/tfd_ram.sv
src/tfd_parse.sv
src/tfd_emit.sv
src/tlv_frame_deframer_crc16_top.sv
bench/tb_top.sv
